// ===== rtl/cdq_pkg.sv =====
// Shared types and constants for the coordinate deque with duplicate check.
package cdq_pkg;

    // Default number of ring entries.
    localparam int DEPTH_DEFAULT = 256;

    // Field widths of one coordinate and of one stored entry.
    localparam int COORD_W = 16;
    localparam int ENTRY_W = 2 * COORD_W;

    // Request action codes.
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_DUP_CHECK  = 3'd4
    } action_t;

    // Result error codes.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } error_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUP_FIRST,
        ST_DUP_SCAN,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/cdq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/coordinate_deque_dup_check_unit.sv =====
// Top level of the coordinate deque with duplicate check.
//
// Requests arrive on the s_axis channel: tuser carries the action and tdata
// the (x,y) coordinate to push. Each request gives exactly one result on the
// m_axis channel: tdata carries the popped coordinate, tuser the empty flag,
// the duplicate verdict and the error code.
// Push, pop and no-op requests go from the idle state straight to ST_RESP:
// the ring memory is written or read at the accepting edge and the result
// register is loaded from its output in ST_RESP. No new request is taken
// before the result of the previous one is loaded.
// A duplicate check walks all stored pairs through the single read port of
// the ring memory and stops early when a duplicate is found; with fewer
// than two entries held it goes straight to ST_RESP.
// The next request is accepted in the cycle after the previous result is
// loaded, even while that result still waits to be taken.
// When the receiver stalls, the result holds in the output register and a
// following request waits before its own result until the register frees.
// Reset empties the deque (head and count to zero) and clears the result
// valid flag; the ring memory itself is not cleared, as only written entries
// are ever read. No clearing pass is needed.
module coordinate_deque_dup_check_unit #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_x[15:0], in_y[31:16]
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_x[15:0], out_y[31:16]
    output logic [3:0]  m_axis_tuser    // is_empty[0], has_duplicate[1], error[3:2]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // Control state.
    cdq_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          out_valid_reg, out_valid_next;

    // Per-request working registers.
    logic                          pop_reg, pop_next;
    logic                          dup_reg, dup_next;
    cdq_pkg::error_t               err_reg, err_next;
    logic [cdq_pkg::ENTRY_W-1:0]   a_reg, a_next;

    // Result register.
    logic [cdq_pkg::ENTRY_W-1:0]   out_data_reg, out_data_next;
    logic                          out_empty_reg, out_empty_next;
    logic                          out_dup_reg, out_dup_next;
    cdq_pkg::error_t               out_err_reg, out_err_next;

    // Ring memory ports.
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [cdq_pkg::ENTRY_W-1:0]   ram_rdata;

    logic             accept;
    logic             load_out;
    cdq_pkg::action_t act;
    logic             scan_hit;
    logic             scan_more_j;
    logic             scan_more_i;

    // Ring position of an offset from the front entry.
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    cdq_ram #(
        .WIDTH (cdq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == cdq_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign act           = cdq_pkg::action_t'(s_axis_tuser);
    assign load_out      = (state_reg == cdq_pkg::ST_RESP) &&
                           (!out_valid_reg || m_axis_tready);

    // Scan decisions for the pair walk.
    assign scan_hit    = (ram_rdata == a_reg);
    assign scan_more_j = ((j_reg + CW'(1)) < count_reg);
    assign scan_more_i = ((i_reg + CW'(2)) < count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (act == cdq_pkg::ACT_DUP_CHECK && count_reg >= CW'(2))
                    begin
                        state_next = cdq_pkg::ST_DUP_FIRST;
                    end
                    else
                    begin
                        state_next = cdq_pkg::ST_RESP;
                    end
                end
            end
            cdq_pkg::ST_DUP_FIRST:
            begin
                state_next = cdq_pkg::ST_DUP_SCAN;
            end
            cdq_pkg::ST_DUP_SCAN:
            begin
                if (scan_hit || !scan_more_j)
                begin
                    if (!scan_hit && scan_more_i)
                    begin
                        state_next = cdq_pkg::ST_DUP_FIRST;
                    end
                    else
                    begin
                        state_next = cdq_pkg::ST_RESP;
                    end
                end
            end
            cdq_pkg::ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = cdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses, deque pointers and per-request working values.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pop_next   = pop_reg;
        dup_next   = dup_reg;
        err_next   = err_reg;
        a_next     = a_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_re     = 1'b0;
        ram_raddr  = head_reg;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pop_next = 1'b0;
                    dup_next = 1'b0;
                    err_next = cdq_pkg::ERR_NONE;
                    case (act)
                        cdq_pkg::ACT_PUSH_FRONT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                err_next = cdq_pkg::ERR_FULL;
                            end
                            else
                            begin
                                head_next  = (head_reg == '0) ? LAST_IDX
                                                              : head_reg - AW'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = head_next;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        cdq_pkg::ACT_PUSH_BACK:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                err_next = cdq_pkg::ERR_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ring_pos(head_reg, count_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        cdq_pkg::ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = cdq_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                pop_next   = 1'b1;
                                head_next  = (head_reg == LAST_IDX) ? '0
                                                                    : head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        cdq_pkg::ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = cdq_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ring_pos(head_reg, count_reg - CW'(1));
                                pop_next   = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        cdq_pkg::ACT_DUP_CHECK:
                        begin
                            // Start the walk with the front entry as the first of a pair.
                            if (count_reg >= CW'(2))
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = head_reg;
                                i_next    = '0;
                                j_next    = CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cdq_pkg::ST_DUP_FIRST:
            begin
                // Hold the first entry of the pair and fetch its first partner.
                a_next    = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = ring_pos(head_reg, j_reg);
            end
            cdq_pkg::ST_DUP_SCAN:
            begin
                if (scan_hit)
                begin
                    dup_next = 1'b1;
                end
                else if (scan_more_j)
                begin
                    j_next    = j_reg + CW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = ring_pos(head_reg, j_reg + CW'(1));
                end
                else if (scan_more_i)
                begin
                    i_next    = i_reg + CW'(1);
                    j_next    = i_reg + CW'(2);
                    ram_re    = 1'b1;
                    ram_raddr = ring_pos(head_reg, i_reg + CW'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register load and release.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_empty_next = out_empty_reg;
        out_dup_next   = out_dup_reg;
        out_err_next   = out_err_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = pop_reg ? ram_rdata : '0;
            out_empty_next = (count_reg == '0);
            out_dup_next   = dup_reg;
            out_err_next   = err_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        pop_reg       <= pop_next;
        dup_reg       <= dup_next;
        err_reg       <= err_next;
        a_reg         <= a_next;
        out_data_reg  <= out_data_next;
        out_empty_reg <= out_empty_next;
        out_dup_reg   <= out_dup_next;
        out_err_reg   <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_err_reg, out_dup_reg, out_empty_reg};

endmodule

// ===== tb/coordinate_deque_dup_check_unit_tb.sv =====
// Self-checking testbench for the coordinate deque with duplicate check.
module coordinate_deque_dup_check_unit_tb;

    localparam int RING_DEPTH = cdq_pkg::DEPTH_DEFAULT;

    // Codes 5 to 7 carry no action and leave the deque alone.
    localparam logic [2:0] ACT_NOP_FIRST = 3'd5;
    localparam logic [2:0] ACT_NOP_LAST  = 3'd7;

    // Cycles without any accepted request or result before the run is abandoned.
    // The longest silent stretch is a duplicate scan of a full ring.
    localparam int STALL_LIMIT = 100000;

    // Number of mismatches that are printed in full.
    localparam int REPORT_LIMIT = 10;

    // One result as the block should produce it.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               empty;
        logic               dup;
        cdq_pkg::error_t    err;
    } deque_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // in_x[15:0], in_y[31:16]
    logic [2:0]  s_axis_tuser;   // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // out_x[15:0], out_y[31:16]
    logic [3:0]  m_axis_tuser;   // is_empty[0], has_duplicate[1], error[3:2]

    // Shadow copy of the deque contents.
    logic [31:0] shadow_ring [RING_DEPTH];
    int          shadow_head;
    int          shadow_count;

    deque_result_t pending_results [$];

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int idle_cycles;

    deque_result_t want;
    deque_result_t got;

    coordinate_deque_dup_check_unit #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock, period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one accepted request to the shadow deque and queue its result.
    task automatic predict_deque_result(input logic [2:0] act, input logic [31:0] coord);
        deque_result_t r;
        logic [31:0]   popped;
        logic [31:0]   first;
        bit            found;
        int            i;
        int            j;
        r      = '0;
        r.err  = cdq_pkg::ERR_NONE;
        popped = '0;
        found  = 1'b0;
        case (act)
            cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_BACK:
            begin
                if (shadow_count >= RING_DEPTH)
                    r.err = cdq_pkg::ERR_FULL;
                else if (act == cdq_pkg::ACT_PUSH_FRONT)
                begin
                    shadow_head = (shadow_head + RING_DEPTH - 1) % RING_DEPTH;
                    shadow_ring[shadow_head] = coord;
                    shadow_count++;
                end
                else
                begin
                    shadow_ring[(shadow_head + shadow_count) % RING_DEPTH] = coord;
                    shadow_count++;
                end
            end
            cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_BACK:
            begin
                if (shadow_count == 0)
                    r.err = cdq_pkg::ERR_EMPTY;
                else if (act == cdq_pkg::ACT_POP_FRONT)
                begin
                    popped = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % RING_DEPTH;
                    shadow_count--;
                end
                else
                begin
                    popped = shadow_ring[(shadow_head + shadow_count - 1) % RING_DEPTH];
                    shadow_count--;
                end
            end
            cdq_pkg::ACT_DUP_CHECK:
            begin
                // Compare every stored pair, in ring order.
                for (i = 0; i + 1 < shadow_count && !found; i++)
                begin
                    first = shadow_ring[(shadow_head + i) % RING_DEPTH];
                    for (j = i + 1; j < shadow_count && !found; j++)
                        if (shadow_ring[(shadow_head + j) % RING_DEPTH] == first)
                            found = 1'b1;
                end
                r.dup = found;
            end
            default:
            begin
            end
        endcase
        r.x     = popped[15:0];
        r.y     = popped[31:16];
        r.empty = (shadow_count == 0);
        pending_results.push_back(r);
    endtask

    // Offer one request, wait for it to be taken, then predict its result.
    task automatic send_request(input logic [2:0] act, input logic [15:0] x,
                                input logic [15:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_deque_result(act, {y, x});
    endtask

    // Coordinate drawn either from a tiny pool, so that repeats are common,
    // or from the whole range.
    function automatic logic [31:0] pick_coord();
        logic [15:0] px;
        logic [15:0] py;
        if ($urandom_range(1) == 1)
        begin
            px = 16'($urandom_range(4)) - 16'd2;
            py = 16'($urandom_range(2)) - 16'd1;
        end
        else
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        return {py, px};
    endfunction

    // Pops, checks and no-op codes on a freshly reset deque.
    task automatic test_empty_deque();
        logic [2:0] code;
        send_request(cdq_pkg::ACT_POP_FRONT, 16'h1234, 16'h5678);
        send_request(cdq_pkg::ACT_POP_BACK, 16'hffff, 16'hffff);
        send_request(cdq_pkg::ACT_DUP_CHECK, 16'h0000, 16'h0000);
        for (code = ACT_NOP_FIRST; code != 3'd0; code++)
            send_request(code, 16'hffff, 16'h8000);
    endtask

    // Every action with extreme coordinates, including a head that wraps.
    task automatic test_basic_ops();
        send_request(cdq_pkg::ACT_PUSH_BACK, 16'h7fff, 16'h8000);
        send_request(cdq_pkg::ACT_DUP_CHECK, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_PUSH_FRONT, 16'h8000, 16'h7fff);
        send_request(cdq_pkg::ACT_PUSH_BACK, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_PUSH_FRONT, 16'hffff, 16'hffff);
        send_request(cdq_pkg::ACT_DUP_CHECK, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_PUSH_BACK, 16'hffff, 16'hffff);
        send_request(cdq_pkg::ACT_DUP_CHECK, 16'h0000, 16'h0000);
        send_request(ACT_NOP_FIRST, 16'hffff, 16'hffff);
        send_request(cdq_pkg::ACT_POP_BACK, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_POP_FRONT, 16'h0000, 16'h0000);
        send_request(ACT_NOP_LAST, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_POP_BACK, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_POP_FRONT, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_POP_BACK, 16'h0000, 16'h0000);
        send_request(cdq_pkg::ACT_POP_FRONT, 16'h0000, 16'h0000);
    endtask

    // Fill the ring from both ends, push onto the full ring, scan it, drain it.
    task automatic test_full_deque();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (i = 0; i < RING_DEPTH; i++)
        begin
            if (i < RING_DEPTH - 56)
                send_request(cdq_pkg::ACT_PUSH_BACK, 16'(i), 16'(i) ^ 16'h8000);
            else
                send_request(cdq_pkg::ACT_PUSH_FRONT, 16'(i), 16'(i) ^ 16'h8000);
        end
        send_request(cdq_pkg::ACT_PUSH_FRONT, 16'h7fff, 16'h7fff);
        send_request(cdq_pkg::ACT_PUSH_BACK, 16'h8000, 16'h8000);
        send_request(cdq_pkg::ACT_DUP_CHECK, 16'h0000, 16'h0000);
        for (i = 0; i < RING_DEPTH; i++)
        begin
            if (i % 2 == 0)
                send_request(cdq_pkg::ACT_POP_FRONT, 16'h0000, 16'h0000);
            else
                send_request(cdq_pkg::ACT_POP_BACK, 16'h0000, 16'h0000);
        end
    endtask

    // Random deque traffic that hovers around a target depth.
    task automatic run_random_phase(input int count, input int idle_pct,
                                    input int stall_pct, input int target);
        int          done;
        int          roll;
        int          push_pct;
        logic [31:0] coord;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < count)
        begin
            roll  = $urandom_range(99);
            coord = pick_coord();
            push_pct = (shadow_count < target) ? 65 : 35;
            if (roll < 4)
            begin
                // No-op codes are noise and are not counted.
                send_request(3'($urandom_range(ACT_NOP_LAST, ACT_NOP_FIRST)),
                             coord[15:0], coord[31:16]);
            end
            else
            begin
                if (roll < 16)
                    send_request(cdq_pkg::ACT_DUP_CHECK, coord[15:0], coord[31:16]);
                else if ($urandom_range(99) < push_pct)
                    send_request($urandom_range(1) ? cdq_pkg::ACT_PUSH_FRONT
                                                   : cdq_pkg::ACT_PUSH_BACK,
                                 coord[15:0], coord[31:16]);
                else
                    send_request($urandom_range(1) ? cdq_pkg::ACT_POP_FRONT
                                                   : cdq_pkg::ACT_POP_BACK,
                                 coord[15:0], coord[31:16]);
                done++;
            end
        end
    endtask

    // Random traffic under each idling pattern in turn.
    task automatic test_random_traffic();
        run_random_phase(230, 0, 0, 6);
        run_random_phase(230, 52, 0, 20);
        run_random_phase(230, 0, 52, 10);
        run_random_phase(230, 34, 34, 32);
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_receiver_hold();
        logic [31:0] coord;
        int          i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 400;
        for (i = 0; i < 16; i++)
        begin
            coord = pick_coord();
            if (i % 4 == 3)
                send_request(cdq_pkg::ACT_POP_BACK, coord[15:0], coord[31:16]);
            else
                send_request(cdq_pkg::ACT_PUSH_BACK, coord[15:0], coord[31:16]);
        end
    endtask

    // Receiver ready, with random stalls and an occasional long hold-off.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x     = m_axis_tdata[15:0];
            got.y     = m_axis_tdata[31:16];
            got.empty = m_axis_tuser[0];
            got.dup   = m_axis_tuser[1];
            got.err   = cdq_pkg::error_t'(m_axis_tuser[3:2]);
            if (pending_results.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("Unexpected result: x=%0d y=%0d empty=%0b dup=%0b err=%0d",
                             got.x, got.y, got.empty, got.dup, got.err);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if ((got.x !== want.x) || (got.y !== want.y) ||
                    (got.empty !== want.empty) || (got.dup !== want.dup) ||
                    (got.err !== want.err))
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("Mismatch: expected x=%0d y=%0d empty=%0b dup=%0b err=%0d",
                                 want.x, want.y, want.empty, want.dup, want.err);
                        $display("          got      x=%0d y=%0d empty=%0b dup=%0b err=%0d",
                                 got.x, got.y, got.empty, got.dup, got.err);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Reset, run every test in turn, drain and report.
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        shadow_head    = 0;
        shadow_count   = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        idle_cycles    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_deque();
        test_basic_ops();
        test_full_deque();
        test_random_traffic();
        test_receiver_hold();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
